### sv/hkmc_pkg.sv
// Package for the hunt-and-kill maze carver.
// Holds opcodes, event codes, phases, direction codes and the direction-order table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hkmc_pkg;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [1:0] CFG_GRID_ROWS = 2'd1;
  localparam logic [1:0] CFG_START_COL = 2'd2;
  localparam logic [1:0] CFG_START_ROW = 2'd3;

  localparam logic [1:0] PH_WALK = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef enum logic [2:0] {
    EV_STARTED      = 3'd0,
    EV_WALKED       = 3'd1,
    EV_HUNT_BEGAN   = 3'd2,
    EV_HUNT_LINKED  = 3'd3,
    EV_COMPLETE     = 3'd4,
    EV_ALREADY_DONE = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    DIR_COL_INC = 2'd0,
    DIR_COL_DEC = 2'd1,
    DIR_ROW_INC = 2'd2,
    DIR_ROW_DEC = 2'd3
  } dir_e;

  // Direction orders in lexicographic order; the first direction sits in bits [1:0].
  localparam logic [7:0] PERM_TAB [24] = '{
    8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
    8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
    8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
    8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
  };

  function automatic logic [7:0] perm_order(input logic [4:0] idx);
    logic [4:0] wrapped;
    wrapped = (idx >= 5'd24) ? (idx - 5'd24) : idx;
    return PERM_TAB[wrapped];
  endfunction

endpackage

`default_nettype wire

### sv/hkmc_bitmap.sv
// Row-organized carved bitmap: one word of carved bits per maze row.
// One write port and one read port with registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hkmc_bitmap #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### sv/hkmc_nbr_unit.sv
// Shared neighbor unit: steps a cell one place in a direction, checks the grid bounds
// and picks the carved bit from the three buffered row words. Uses hkmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hkmc_nbr_unit
  import hkmc_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire dir_e              dir_i,
  input  wire logic [CW-1:0]     col_i,
  input  wire logic [RW-1:0]     row_i,
  input  wire logic [CW:0]       eff_cols_i,
  input  wire logic [RW:0]       eff_rows_i,
  input  wire logic [MAX_COLS-1:0] row_up_i,
  input  wire logic [MAX_COLS-1:0] row_mid_i,
  input  wire logic [MAX_COLS-1:0] row_dn_i,
  output logic                   ok_o,
  output logic      [CW-1:0]     col_o,
  output logic      [RW-1:0]     row_o,
  output logic [MAX_COLS-1:0]    word_o,
  output logic                   carved_o
);

  logic [CW:0] col_inc;
  logic [RW:0] row_inc;
  logic [CW:0] col_cand;
  logic [RW:0] row_cand;
  logic        under;

  assign col_inc = {1'b0, col_i} + {{CW{1'b0}}, 1'b1};
  assign row_inc = {1'b0, row_i} + {{RW{1'b0}}, 1'b1};

  // The stepped cell must lie inside the grid in both coordinates, since the walker
  // can sit outside a grid that shrank in mid-maze.
  always_comb begin
    under    = 1'b0;
    col_cand = {1'b0, col_i};
    row_cand = {1'b0, row_i};
    word_o   = row_mid_i;
    unique case (dir_i)
      DIR_COL_INC: begin
        col_cand = col_inc;
      end
      DIR_COL_DEC: begin
        under    = col_i == '0;
        col_cand = {1'b0, col_i} - {{CW{1'b0}}, 1'b1};
      end
      DIR_ROW_INC: begin
        row_cand = row_inc;
        word_o   = row_dn_i;
      end
      DIR_ROW_DEC: begin
        under    = row_i == '0;
        row_cand = {1'b0, row_i} - {{RW{1'b0}}, 1'b1};
        word_o   = row_up_i;
      end
      default: begin
        under = 1'b1;
      end
    endcase
    ok_o  = !under && (col_cand < eff_cols_i) && (row_cand < eff_rows_i);
    col_o = col_cand[CW-1:0];
    row_o = row_cand[RW-1:0];
  end

  assign carved_o = word_o[col_o];

endmodule

`default_nettype wire

### sv/hunt_and_kill_maze_carver_core.sv
// Top level of the hunt-and-kill maze carver: configuration registers, sequencer,
// row window and result register. Uses hkmc_pkg, hkmc_bitmap and hkmc_nbr_unit.
//
// The input channel takes one item (opcode, rand_perm) at a time and every item
// produces exactly one result item (event_res, from/to coordinates) on the output
// channel. The configuration channel is always ready; it must be written only while
// idle, which the block itself does not enforce. A start item sweeps the bitmap one
// row word a cycle. A walk step loads the walker's row and its two neighbor rows
// through the single read port, then tries one direction a cycle in the shared
// neighbor unit. A hunt step loads each scanned row and then checks one cell a
// cycle, trying one direction a cycle on an uncarved cell. An advance after
// completion goes straight to its result. The input is not ready while an item is
// in work.
// A finished result waits in the output register; the next item is accepted while
// it waits, and the sequencer holds its next result until the register is free.
// After reset the maze counts as finished and the bitmap content is undefined
// until the first start item clears it.
`timescale 1ns / 1ps
`default_nettype none

module hunt_and_kill_maze_carver_core
  import hkmc_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       opcode_i,
  input  wire logic [4:0] rand_perm_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      event_res_o,
  output logic [5:0]      from_col_o,
  output logic [5:0]      from_row_o,
  output logic [5:0]      to_col_o,
  output logic [5:0]      to_row_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_WDIR  = 3'd3;
  localparam logic [2:0] S_HCELL = 3'd4;
  localparam logic [2:0] S_HDIR  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [6:0] grid_cols_q, grid_rows_q;
  logic [5:0] start_col_q, start_row_q;

  logic [2:0] state_q, state_d;
  logic [1:0] sub_q, sub_d;
  logic [1:0] k_q, k_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] order_q, order_d;
  logic [CW-1:0] walker_col_q, walker_col_d, scan_col_q, scan_col_d;
  logic [RW-1:0] walker_row_q, walker_row_d, scan_row_q, scan_row_d;
  logic [MAX_COLS-1:0] win_q [3];
  logic [MAX_COLS-1:0] win_d [3];

  event_e        res_ev_q, res_ev_d;
  logic [CW-1:0] res_fc_q, res_fc_d, res_tc_q, res_tc_d;
  logic [RW-1:0] res_fr_q, res_fr_d, res_tr_q, res_tr_d;

  logic out_valid_q;
  logic emit_fire;

  logic [CW:0]   eff_cols;
  logic [RW:0]   eff_rows;
  logic [CW-1:0] start_col_eff;
  logic [RW-1:0] start_row_eff;

  logic                mem_rd_en, mem_wr_en;
  logic [RW-1:0]       mem_rd_addr, mem_wr_addr;
  logic [MAX_COLS-1:0] mem_rd_data, mem_wr_data;

  dir_e                nb_dir;
  logic [CW-1:0]       nb_col_in, nb_col;
  logic [RW-1:0]       nb_row_in, nb_row;
  logic                nb_ok, nb_carved;
  logic [MAX_COLS-1:0] nb_word;

  logic [RW-1:0]       row_base;
  logic                adv;
  logic                last_col, last_row;
  logic [MAX_COLS-1:0] word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= 7'd64;
      grid_rows_q <= 7'd64;
      start_col_q <= 6'd0;
      start_row_q <= 6'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        CFG_START_COL: start_col_q <= cfg_data_i[5:0];
        CFG_START_ROW: start_row_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (grid_cols_q == 7'd0) begin
      eff_cols = (CW+1)'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      eff_cols = (CW+1)'(MAX_COLS);
    end else begin
      eff_cols = (CW+1)'(grid_cols_q);
    end
    if (grid_rows_q == 7'd0) begin
      eff_rows = (RW+1)'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      eff_rows = (RW+1)'(MAX_ROWS);
    end else begin
      eff_rows = (RW+1)'(grid_rows_q);
    end
    if (32'(start_col_q) < 32'(eff_cols)) begin
      start_col_eff = CW'(start_col_q);
    end else begin
      start_col_eff = CW'(eff_cols - (CW+1)'(1));
    end
    if (32'(start_row_q) < 32'(eff_rows)) begin
      start_row_eff = RW'(start_row_q);
    end else begin
      start_row_eff = RW'(eff_rows - (RW+1)'(1));
    end
  end

  hkmc_bitmap #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

  assign nb_dir    = dir_e'(order_q[2*k_q +: 2]);
  assign nb_col_in = (state_q == S_WDIR) ? walker_col_q : scan_col_q;
  assign nb_row_in = (state_q == S_WDIR) ? walker_row_q : scan_row_q;

  hkmc_nbr_unit #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_nbr (
    .dir_i     (nb_dir),
    .col_i     (nb_col_in),
    .row_i     (nb_row_in),
    .eff_cols_i(eff_cols),
    .eff_rows_i(eff_rows),
    .row_up_i  (win_q[0]),
    .row_mid_i (win_q[1]),
    .row_dn_i  (win_q[2]),
    .ok_o      (nb_ok),
    .col_o     (nb_col),
    .row_o     (nb_row),
    .word_o    (nb_word),
    .carved_o  (nb_carved)
  );

  assign row_base  = (phase_q == PH_WALK) ? walker_row_q : scan_row_q;
  assign last_col  = {1'b0, scan_col_q} == (eff_cols - (CW+1)'(1));
  assign last_row  = {1'b0, scan_row_q} == (eff_rows - (RW+1)'(1));
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    sub_d        = sub_q;
    k_d          = k_q;
    phase_d      = phase_q;
    order_d      = order_q;
    walker_col_d = walker_col_q;
    walker_row_d = walker_row_q;
    scan_col_d   = scan_col_q;
    scan_row_d   = scan_row_q;
    win_d        = win_q;
    res_ev_d     = res_ev_q;
    res_fc_d     = res_fc_q;
    res_fr_d     = res_fr_q;
    res_tc_d     = res_tc_q;
    res_tr_d     = res_tr_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = row_base;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = scan_row_q;
    mem_wr_data  = '0;
    adv          = 1'b0;
    word         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          order_d = perm_order(rand_perm_i);
          if (opcode_i == OP_START) begin
            scan_row_d = '0;
            state_d    = S_CLEAR;
          end else begin
            case (phase_q)
              PH_WALK: begin
                sub_d   = 2'd0;
                state_d = S_LOAD;
              end
              PH_HUNT: begin
                scan_row_d = '0;
                scan_col_d = '0;
                sub_d      = 2'd0;
                state_d    = S_LOAD;
              end
              default: begin
                res_ev_d = EV_ALREADY_DONE;
                res_fc_d = walker_col_q;
                res_fr_d = walker_row_q;
                res_tc_d = walker_col_q;
                res_tr_d = walker_row_q;
                state_d  = S_EMIT;
              end
            endcase
          end
        end
      end
      S_CLEAR: begin
        word[start_col_eff] = 1'b1;
        mem_wr_en   = 1'b1;
        mem_wr_addr = scan_row_q;
        mem_wr_data = (scan_row_q == start_row_eff) ? word : '0;
        if (scan_row_q == LAST_ROW) begin
          scan_row_d   = '0;
          scan_col_d   = '0;
          walker_col_d = start_col_eff;
          walker_row_d = start_row_eff;
          phase_d      = PH_WALK;
          res_ev_d     = EV_STARTED;
          res_fc_d     = start_col_eff;
          res_fr_d     = start_row_eff;
          res_tc_d     = start_col_eff;
          res_tr_d     = start_row_eff;
          state_d      = S_EMIT;
        end else begin
          scan_row_d = scan_row_q + {{(RW-1){1'b0}}, 1'b1};
        end
      end
      S_LOAD: begin
        mem_rd_en = sub_q != 2'd3;
        case (sub_q)
          2'd0: mem_rd_addr = (row_base == '0) ? row_base
                              : row_base - {{(RW-1){1'b0}}, 1'b1};
          2'd1: mem_rd_addr = row_base;
          default: mem_rd_addr = (row_base == LAST_ROW) ? row_base
                                 : row_base + {{(RW-1){1'b0}}, 1'b1};
        endcase
        case (sub_q)
          2'd1: win_d[0] = mem_rd_data;
          2'd2: win_d[1] = mem_rd_data;
          2'd3: win_d[2] = mem_rd_data;
          default: ;
        endcase
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          k_d     = 2'd0;
          state_d = (phase_q == PH_WALK) ? S_WDIR : S_HCELL;
        end
      end
      S_WDIR: begin
        if (nb_ok && !nb_carved) begin
          word         = nb_word;
          word[nb_col] = 1'b1;
          mem_wr_en    = 1'b1;
          mem_wr_addr  = nb_row;
          mem_wr_data  = word;
          walker_col_d = nb_col;
          walker_row_d = nb_row;
          res_ev_d     = EV_WALKED;
          res_fc_d     = walker_col_q;
          res_fr_d     = walker_row_q;
          res_tc_d     = nb_col;
          res_tr_d     = nb_row;
          state_d      = S_EMIT;
        end else if (k_q == 2'd3) begin
          phase_d    = PH_HUNT;
          scan_col_d = '0;
          scan_row_d = '0;
          res_ev_d   = EV_HUNT_BEGAN;
          res_fc_d   = walker_col_q;
          res_fr_d   = walker_row_q;
          res_tc_d   = walker_col_q;
          res_tr_d   = walker_row_q;
          state_d    = S_EMIT;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_HCELL: begin
        if (win_q[1][scan_col_q]) begin
          adv = 1'b1;
        end else begin
          k_d     = 2'd0;
          state_d = S_HDIR;
        end
      end
      S_HDIR: begin
        if (nb_ok && nb_carved) begin
          word             = win_q[1];
          word[scan_col_q] = 1'b1;
          mem_wr_en        = 1'b1;
          mem_wr_addr      = scan_row_q;
          mem_wr_data      = word;
          walker_col_d     = scan_col_q;
          walker_row_d     = scan_row_q;
          phase_d          = PH_WALK;
          res_ev_d         = EV_HUNT_LINKED;
          res_fc_d         = nb_col;
          res_fr_d         = nb_row;
          res_tc_d         = scan_col_q;
          res_tr_d         = scan_row_q;
          state_d          = S_EMIT;
        end else if (k_q == 2'd3) begin
          adv = 1'b1;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (adv) begin
      if (!last_col) begin
        scan_col_d = scan_col_q + {{(CW-1){1'b0}}, 1'b1};
        state_d    = S_HCELL;
      end else if (!last_row) begin
        scan_col_d = '0;
        scan_row_d = scan_row_q + {{(RW-1){1'b0}}, 1'b1};
        sub_d      = 2'd0;
        state_d    = S_LOAD;
      end else begin
        phase_d  = PH_DONE;
        res_ev_d = EV_COMPLETE;
        res_fc_d = walker_col_q;
        res_fr_d = walker_row_q;
        res_tc_d = walker_col_q;
        res_tr_d = walker_row_q;
        state_d  = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sub_q        <= 2'd0;
      k_q          <= 2'd0;
      phase_q      <= PH_DONE;
      walker_col_q <= '0;
      walker_row_q <= '0;
      scan_col_q   <= '0;
      scan_row_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sub_q        <= sub_d;
      k_q          <= k_d;
      phase_q      <= phase_d;
      walker_col_q <= walker_col_d;
      walker_row_q <= walker_row_d;
      scan_col_q   <= scan_col_d;
      scan_row_q   <= scan_row_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    order_q  <= order_d;
    win_q    <= win_d;
    res_ev_q <= res_ev_d;
    res_fc_q <= res_fc_d;
    res_fr_q <= res_fr_d;
    res_tc_q <= res_tc_d;
    res_tr_q <= res_tr_d;
    if (emit_fire) begin
      event_res_o <= res_ev_q;
      from_col_o  <= 6'(res_fc_q);
      from_row_o  <= 6'(res_fr_q);
      to_col_o    <= 6'(res_tc_q);
      to_row_o    <= 6'(res_tr_q);
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd_en && mem_wr_en))
    else $error("bitmap read and write issued in the same cycle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_valid_o && state_q == S_IDLE)
    else $error("result did not reach the output register");

  a_walk_write_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en && (state_q == S_WDIR || state_q == S_HDIR) |-> nb_ok && phase_d == PH_WALK)
    else $error("carve outside the grid or without a walk phase");

endmodule

`default_nettype wire

### tb/hunt_and_kill_maze_carver_core_tb.sv
// Self-checking testbench for hunt_and_kill_maze_carver_core: directed and random mazes
// checked against a behavioral model of the carver, with random idling and backpressure.
// Depends on hkmc_pkg and the carver RTL only.
`timescale 1ns / 1ps

module hunt_and_kill_maze_carver_core_tb;
  import hkmc_pkg::*;

  localparam int MAX_COLS       = 64;
  localparam int MAX_ROWS       = 64;
  localparam int ITEM_TARGET    = 650;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 50;

  typedef logic [3:0][1:0] dir_order_t;

  typedef struct packed {
    event_e     ev;
    logic [5:0] from_col;
    logic [5:0] from_row;
    logic [5:0] to_col;
    logic [5:0] to_row;
  } carve_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       opcode_i    = OP_START;
  logic [4:0] rand_perm_i = '0;
  logic       out_ready_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_GRID_COLS;
  logic [6:0] cfg_data_i  = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] event_res_o;
  logic [5:0] from_col_o;
  logic [5:0] from_row_o;
  logic [5:0] to_col_o;
  logic [5:0] to_row_o;
  logic       cfg_ready_o;

  hunt_and_kill_maze_carver_core #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .rand_perm_i(rand_perm_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .event_res_o(event_res_o),
    .from_col_o (from_col_o),
    .from_row_o (from_row_o),
    .to_col_o   (to_col_o),
    .to_row_o   (to_row_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Model state of the carver and its configuration.
  bit         carved_q [MAX_ROWS][MAX_COLS];
  logic [5:0] walk_col;
  logic [5:0] walk_row;
  logic [5:0] scan_col;
  logic [5:0] scan_row;
  logic [1:0] phase_q = PH_DONE;
  logic [6:0] grid_cols_q = 7'd64;
  logic [6:0] grid_rows_q = 7'd64;
  logic [5:0] start_col_q = '0;
  logic [5:0] start_row_q = '0;

  carve_result_t expected_events [$];
  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int burst_left    = 0;
  int stall_cycles  = 0;
  int hold_left     = 0;
  int holds_done    = 0;
  int next_hold_at  = 150;
  int ready_mode    = 0;
  int ready_mode_left = 0;

  function automatic int clamp_dim(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  function automatic dir_order_t direction_order(input logic [4:0] perm);
    int pool [4];
    int fact [4];
    int p, k, left;
    dir_order_t ord;
    pool = '{0, 1, 2, 3};
    fact = '{6, 2, 1, 1};
    p = int'(perm) % 24;
    left = 4;
    for (int i = 0; i < 4; i++) begin
      k = p / fact[i];
      p = p % fact[i];
      if (k >= left) k = left - 1;
      ord[i] = 2'(pool[k]);
      for (int j = k; j < left - 1; j++) pool[j] = pool[j + 1];
      left--;
    end
    return ord;
  endfunction

  function automatic bit neighbor_of(input int c, input int r, input logic [1:0] d,
                                     input int ec, input int er,
                                     output int nc, output int nr);
    nc = c;
    nr = r;
    case (dir_e'(d))
      DIR_COL_INC: nc = c + 1;
      DIR_COL_DEC: nc = c - 1;
      DIR_ROW_INC: nr = r + 1;
      default:     nr = r - 1;
    endcase
    return nc >= 0 && nr >= 0 && nc < ec && nr < er;
  endfunction

  function automatic carve_result_t make_result(input event_e ev, input int fc, input int fr,
                                                input int tc, input int tr);
    carve_result_t res;
    res.ev = ev;
    res.from_col = 6'(fc);
    res.from_row = 6'(fr);
    res.to_col = 6'(tc);
    res.to_row = 6'(tr);
    return res;
  endfunction

  function automatic carve_result_t carve_predict(input logic op, input logic [4:0] perm);
    dir_order_t order;
    int ec, er, nc, nr;
    order = direction_order(perm);
    ec = clamp_dim(grid_cols_q);
    er = clamp_dim(grid_rows_q);
    if (op == OP_START) begin
      for (int r = 0; r < MAX_ROWS; r++)
        for (int c = 0; c < MAX_COLS; c++) carved_q[r][c] = 1'b0;
      walk_col = (int'(start_col_q) < ec) ? start_col_q : 6'(ec - 1);
      walk_row = (int'(start_row_q) < er) ? start_row_q : 6'(er - 1);
      carved_q[walk_row][walk_col] = 1'b1;
      scan_col = '0;
      scan_row = '0;
      phase_q = PH_WALK;
      return make_result(EV_STARTED, walk_col, walk_row, walk_col, walk_row);
    end
    if (phase_q == PH_WALK) begin
      for (int i = 0; i < 4; i++) begin
        if (neighbor_of(walk_col, walk_row, order[i], ec, er, nc, nr) && !carved_q[nr][nc]) begin
          carve_result_t res;
          res = make_result(EV_WALKED, walk_col, walk_row, nc, nr);
          carved_q[nr][nc] = 1'b1;
          walk_col = 6'(nc);
          walk_row = 6'(nr);
          return res;
        end
      end
      phase_q = PH_HUNT;
      scan_col = '0;
      scan_row = '0;
      return make_result(EV_HUNT_BEGAN, walk_col, walk_row, walk_col, walk_row);
    end
    if (phase_q == PH_HUNT) begin
      for (int r = 0; r < er; r++) begin
        for (int c = 0; c < ec; c++) begin
          if (!carved_q[r][c]) begin
            for (int i = 0; i < 4; i++) begin
              if (neighbor_of(c, r, order[i], ec, er, nc, nr) && carved_q[nr][nc]) begin
                carved_q[r][c] = 1'b1;
                walk_col = 6'(c);
                walk_row = 6'(r);
                scan_col = 6'(c);
                scan_row = 6'(r);
                phase_q = PH_WALK;
                return make_result(EV_HUNT_LINKED, nc, nr, c, r);
              end
            end
          end
        end
      end
      phase_q = PH_DONE;
      return make_result(EV_COMPLETE, walk_col, walk_row, walk_col, walk_row);
    end
    return make_result(EV_ALREADY_DONE, walk_col, walk_row, walk_col, walk_row);
  endfunction

  function automatic logic [6:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 7'd0;
    if (sel == 1) return 7'($urandom_range(65, 127));
    if (sel == 2) return 7'd64;
    if (sel <= 5) return 7'($urandom_range(7, 12));
    return 7'($urandom_range(1, 6));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input logic op, input logic [4:0] perm);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    rand_perm_i <= perm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_events.push_back(carve_predict(op, perm));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GRID_COLS: grid_cols_q = data;
      CFG_GRID_ROWS: grid_rows_q = data;
      CFG_START_COL: start_col_q = data[5:0];
      default:       start_row_q = data[5:0];
    endcase
  endtask

  task automatic set_grid(input logic [6:0] cols, input logic [6:0] rows,
                          input logic [5:0] scol, input logic [5:0] srow);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_START_COL, {1'b0, scol});
    write_reg(CFG_START_ROW, {1'b0, srow});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Advance items before any start must report that the maze is already finished.
  task automatic test_advance_before_start();
    send_item(OP_ADVANCE, 5'd0);
    send_item(OP_ADVANCE, 5'd23);
    send_item(OP_ADVANCE, 5'd31);
  endtask

  // Zero grid size clamps to one cell, and the start cell saturates into it.
  task automatic test_single_cell_grid();
    drain_results();
    set_grid(7'd0, 7'd0, 6'd63, 6'd63);
    send_item(OP_START, 5'd0);
    repeat (3) send_item(OP_ADVANCE, 5'd7);
  endtask

  // Oversized grid clamps to the maximum; the walk starts in the far corner.
  task automatic test_corner_walk();
    drain_results();
    set_grid(7'd127, 7'd70, 6'd63, 6'd63);
    send_item(OP_START, 5'd12);
    send_item(OP_ADVANCE, 5'd0);
    send_item(OP_ADVANCE, 5'd23);
    send_item(OP_ADVANCE, 5'd24);
    send_item(OP_ADVANCE, 5'd31);
    send_item(OP_ADVANCE, 5'd5);
    send_item(OP_ADVANCE, 5'd17);
  endtask

  // A walk from the middle of a 3 by 1 strip must hunt to reach the other end.
  task automatic test_hunt_link();
    drain_results();
    set_grid(7'd3, 7'd1, 6'd1, 6'd0);
    send_item(OP_START, 5'd3);
    send_item(OP_ADVANCE, 5'd0);
    send_item(OP_ADVANCE, 5'd6);
    send_item(OP_ADVANCE, 5'd18);
    send_item(OP_ADVANCE, 5'd9);
    send_item(OP_ADVANCE, 5'd30);
    send_item(OP_ADVANCE, 5'd14);
    send_item(OP_ADVANCE, 5'd1);
  endtask

  task automatic test_random_mazes();
    logic [6:0] cols, rows;
    logic [5:0] scol, srow;
    int ec, er, cells, steps;
    while (items_sent < ITEM_TARGET) begin
      cols = pick_dim();
      rows = pick_dim();
      ec = clamp_dim(cols);
      er = clamp_dim(rows);
      scol = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, ec - 1));
      srow = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, er - 1));
      cells = ec * er;
      steps = (cells <= 48) ? $urandom_range(cells, 2 * cells + 4) : $urandom_range(20, 60);
      drain_results();
      set_grid(cols, rows, scol, srow);
      send_item(OP_START, 5'($urandom_range(0, 31)));
      for (int k = 0; k < steps; k++) begin
        if (k == steps / 2 && $urandom_range(0, 4) == 0) begin
          drain_results();
          set_grid(pick_dim(), pick_dim(), scol, srow);
        end
        send_item(($urandom_range(0, 39) == 0) ? OP_START : OP_ADVANCE,
                  5'($urandom_range(0, 31)));
      end
    end
  endtask

  // The receiver stalls on its own pattern and twice holds off for a long stretch.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holds_done < 2 && results_seen >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      next_hold_at += 300;
      out_ready_i <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_mode_left = $urandom_range(1, 40);
      end
      ready_mode_left--;
      case (ready_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin : check_result
      carve_result_t want;
      results_seen++;
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected result event", event_res_o, -1);
      end else begin
        want = expected_events.pop_front();
        if (event_res_o !== want.ev) report_mismatch("event", event_res_o, want.ev);
        if (from_col_o !== want.from_col) report_mismatch("from_col", from_col_o, want.from_col);
        if (from_row_o !== want.from_row) report_mismatch("from_row", from_row_o, want.from_row);
        if (to_col_o !== want.to_col) report_mismatch("to_col", to_col_o, want.to_col);
        if (to_row_o !== want.to_row) report_mismatch("to_row", to_row_o, want.to_row);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_advance_before_start();
    test_single_cell_grid();
    test_corner_walk();
    test_hunt_link();
    test_random_mazes();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
